>>> rtl/lkg_pkg.sv
// ----------------------------------------------------------------------------
// lkg_pkg
// Shared types and constants of the linked list group reverser.
// ----------------------------------------------------------------------------
package lkg_pkg;

    localparam int GS_BITS       = 7;
    localparam int HEAD_BITS     = 17;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [GS_BITS-1:0] GS_RESET = 7'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic REG_GROUP_SIZE   = 1'b0;
    localparam logic REG_HEAD_ADDRESS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_GATHER = 4'b0010,
        ST_LOOK   = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

endpackage

>>> rtl/lkg_if.sv
// ----------------------------------------------------------------------------
// lkg_if
// Request and result channels of the linked list group reverser.
// ----------------------------------------------------------------------------
interface lkg_cmd_if #(
    parameter int ADDR_BITS = 17,
    parameter int DATA_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [ADDR_BITS-1:0]        node_address;
    logic signed [DATA_BITS-1:0] node_value;
    logic [ADDR_BITS-1:0]        link_address;
    logic                        link_is_end;

    modport source (
        output valid, op, node_address, node_value, link_address, link_is_end,
        input  ready
    );
    modport sink (
        input  valid, op, node_address, node_value, link_address, link_is_end,
        output ready
    );
endinterface

interface lkg_res_if #(
    parameter int ADDR_BITS = 17,
    parameter int DATA_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic [ADDR_BITS-1:0]        out_address;
    logic signed [DATA_BITS-1:0] out_value;
    logic [ADDR_BITS-1:0]        follow_address;
    logic                        follow_is_end;
    logic                        last_of_run;

    modport source (
        output valid, out_address, out_value, follow_address, follow_is_end, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_address, out_value, follow_address, follow_is_end, last_of_run,
        output ready
    );
endinterface

>>> rtl/lkg_node_store.sv
// ----------------------------------------------------------------------------
// lkg_node_store
// Address-indexed value and link tables with one write and one read port.
// ----------------------------------------------------------------------------
module lkg_node_store #(
    parameter int ADDR_BITS = 17,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_value,
    input  logic [ADDR_BITS:0]   wr_link,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_value,
    output logic [ADDR_BITS:0]   rd_link
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] value_mem [DEPTH];
    logic [ADDR_BITS:0]   link_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            link_mem[wr_addr]  <= wr_link;
        end
        rd_value <= value_mem[rd_addr];
        rd_link  <= link_mem[rd_addr];
    end

endmodule

>>> rtl/linked_list_k_group_reverser.sv
// ----------------------------------------------------------------------------
// linked_list_k_group_reverser
// A load transfer is taken only while idle and writes the node tables. An
// emit transfer of a group of n nodes with lookahead over up to k nodes makes
// one dependent link table read per node, then one group buffer read per
// result, results leaving at one per cycle while res.ready stays high.
// Reset clears the control state, sets group_size to 1 and head_address to 0;
// the node tables and the group buffer are not cleared.
// ----------------------------------------------------------------------------
module linked_list_k_group_reverser
    import lkg_pkg::*;
#(
    parameter int ADDR_BITS = 17,
    parameter int GROUP_MAX = 64,
    parameter int DATA_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    lkg_cmd_if.sink                  cmd,
    lkg_res_if.source                res
);

    localparam int CNT_BITS = $clog2(GROUP_MAX + 1);
    localparam int IDX_BITS = $clog2(GROUP_MAX);
    localparam int BUF_BITS = ADDR_BITS + DATA_BITS;

    state_t                state_reg, state_next;
    logic [GS_BITS-1:0]    gs_reg, gs_next;
    logic [HEAD_BITS-1:0]  head_reg, head_next;
    logic                  walk_started_reg, walk_started_next;
    logic [ADDR_BITS-1:0]  walk_ptr_reg, walk_ptr_next;
    logic                  walk_end_reg, walk_end_next;
    logic [CNT_BITS-1:0]   k_reg, k_next;
    logic [CNT_BITS-1:0]   n_reg, n_next;
    logic [CNT_BITS-1:0]   m_reg, m_next;
    logic [CNT_BITS-1:0]   i_reg, i_next;
    logic                  full_reg, full_next;
    logic                  follow_end_reg, follow_end_next;
    logic                  data_avail_reg, data_avail_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ADDR_BITS-1:0]  cur_reg, cur_next;
    logic [ADDR_BITS-1:0]  p_reg, p_next;
    logic [ADDR_BITS-1:0]  follow_reg, follow_next;

    logic [BUF_BITS-1:0]   buf_mem [GROUP_MAX];
    logic [BUF_BITS-1:0]   buf_rd_reg;
    logic [ADDR_BITS-1:0]  buf_follow_reg;
    logic                  data_last_reg;

    logic [ADDR_BITS-1:0]  out_addr_reg;
    logic [DATA_BITS-1:0]  out_value_reg;
    logic [ADDR_BITS-1:0]  out_follow_reg;
    logic                  out_follow_end_reg;
    logic                  out_last_reg;

    logic                  cmd_fire;
    logic                  cfg_wr;
    logic                  st_wr_en;
    logic [ADDR_BITS-1:0]  st_rd_addr;
    logic [DATA_BITS-1:0]  st_rd_value;
    logic [ADDR_BITS:0]    st_rd_link;
    logic [ADDR_BITS-1:0]  link_addr;
    logic                  link_end;
    logic [ADDR_BITS-1:0]  start_addr;
    logic                  start_end;
    logic [CNT_BITS-1:0]   k_eff;
    logic [CNT_BITS-1:0]   n_inc;
    logic [CNT_BITS-1:0]   m_inc;
    logic [CNT_BITS-1:0]   rd_idx;
    logic [CNT_BITS-1:0]   nx_idx;
    logic                  buf_we;
    logic                  move;
    logic                  issue;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign prdata   = (paddr[2] == REG_HEAD_ADDRESS) ? APB_DATA_BITS'(head_reg)
                                                     : APB_DATA_BITS'(gs_reg);

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid & cmd.ready;
    assign st_wr_en  = cmd_fire & (cmd.op == OP_LOAD);

    assign link_addr  = st_rd_link[ADDR_BITS-1:0];
    assign link_end   = st_rd_link[ADDR_BITS];
    assign start_addr = walk_started_reg ? walk_ptr_reg : ADDR_BITS'(head_reg);
    assign start_end  = walk_started_reg & walk_end_reg;
    assign st_rd_addr = (state_reg == ST_IDLE) ? start_addr : link_addr;

    assign k_eff = (gs_reg < GS_BITS'(2)) ? CNT_BITS'(1) :
                   (gs_reg > GS_BITS'(GROUP_MAX)) ? CNT_BITS'(GROUP_MAX) :
                   CNT_BITS'(gs_reg);

    assign n_inc  = n_reg + CNT_BITS'(1);
    assign m_inc  = m_reg + CNT_BITS'(1);
    assign rd_idx = full_reg ? (n_reg - i_reg - CNT_BITS'(1)) : i_reg;
    assign nx_idx = full_reg ? (n_reg - i_reg - CNT_BITS'(2)) : (i_reg + CNT_BITS'(1));
    assign buf_we = (state_reg == ST_GATHER);

    assign move  = data_avail_reg & (~out_valid_reg | res.ready);
    assign issue = (state_reg == ST_EMIT) & (i_reg != n_reg) & (~data_avail_reg | move);

    assign data_avail_next = issue | (data_avail_reg & ~move);
    assign out_valid_next  = move | (out_valid_reg & ~res.ready);

    lkg_node_store #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_store (
        .clk      (clk),
        .wr_en    (st_wr_en),
        .wr_addr  (cmd.node_address),
        .wr_value (cmd.node_value),
        .wr_link  ({cmd.link_is_end, cmd.link_address}),
        .rd_addr  (st_rd_addr),
        .rd_value (st_rd_value),
        .rd_link  (st_rd_link)
    );

    always_comb
    begin
        state_next        = state_reg;
        gs_next           = gs_reg;
        head_next         = head_reg;
        walk_started_next = walk_started_reg;
        walk_ptr_next     = walk_ptr_reg;
        walk_end_next     = walk_end_reg;
        k_next            = k_reg;
        n_next            = n_reg;
        m_next            = m_reg;
        i_next            = i_reg;
        full_next         = full_reg;
        follow_end_next   = follow_end_reg;
        cur_next          = cur_reg;
        p_next            = p_reg;
        follow_next       = follow_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.op == OP_EMIT))
                begin
                    walk_started_next = 1'b1;
                    walk_ptr_next     = start_addr;
                    walk_end_next     = start_end;
                    if (!start_end)
                    begin
                        cur_next   = start_addr;
                        n_next     = '0;
                        k_next     = k_eff;
                        state_next = ST_GATHER;
                    end
                end
            end
            ST_GATHER:
            begin
                n_next   = n_inc;
                cur_next = link_addr;
                if (link_end)
                begin
                    walk_end_next   = 1'b1;
                    follow_end_next = 1'b1;
                    full_next       = (n_inc == k_reg);
                    i_next          = '0;
                    state_next      = ST_EMIT;
                end
                else if (n_inc == k_reg)
                begin
                    p_next          = link_addr;
                    walk_ptr_next   = link_addr;
                    full_next       = 1'b1;
                    follow_end_next = 1'b0;
                    m_next          = '0;
                    state_next      = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                m_next   = m_inc;
                cur_next = link_addr;
                if (m_inc == k_reg)
                begin
                    follow_next = cur_reg;
                    i_next      = '0;
                    state_next  = ST_EMIT;
                end
                else if (link_end)
                begin
                    follow_next = p_reg;
                    i_next      = '0;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    i_next = i_reg + CNT_BITS'(1);
                end
                if ((i_reg == n_reg) && (!data_avail_reg || move))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            if (paddr[2] == REG_GROUP_SIZE)
            begin
                gs_next = pwdata[GS_BITS-1:0];
            end
            else if (paddr[2] == REG_HEAD_ADDRESS)
            begin
                head_next         = pwdata[HEAD_BITS-1:0];
                walk_started_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            gs_reg           <= GS_RESET;
            head_reg         <= '0;
            walk_started_reg <= 1'b0;
            walk_ptr_reg     <= '0;
            walk_end_reg     <= 1'b0;
            k_reg            <= CNT_BITS'(1);
            n_reg            <= '0;
            m_reg            <= '0;
            i_reg            <= '0;
            full_reg         <= 1'b0;
            follow_end_reg   <= 1'b0;
            data_avail_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            gs_reg           <= gs_next;
            head_reg         <= head_next;
            walk_started_reg <= walk_started_next;
            walk_ptr_reg     <= walk_ptr_next;
            walk_end_reg     <= walk_end_next;
            k_reg            <= k_next;
            n_reg            <= n_next;
            m_reg            <= m_next;
            i_reg            <= i_next;
            full_reg         <= full_next;
            follow_end_reg   <= follow_end_next;
            data_avail_reg   <= data_avail_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        p_reg      <= p_next;
        follow_reg <= follow_next;
        if (move)
        begin
            out_addr_reg       <= buf_rd_reg[BUF_BITS-1 -: ADDR_BITS];
            out_value_reg      <= buf_rd_reg[DATA_BITS-1:0];
            out_follow_reg     <= data_last_reg ? (follow_end_reg ? '0 : follow_reg)
                                                : buf_follow_reg;
            out_follow_end_reg <= data_last_reg & follow_end_reg;
            out_last_reg       <= data_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[n_reg[IDX_BITS-1:0]] <= {cur_reg, st_rd_value};
        end
        if (issue)
        begin
            buf_rd_reg     <= buf_mem[rd_idx[IDX_BITS-1:0]];
            buf_follow_reg <= buf_mem[nx_idx[IDX_BITS-1:0]][BUF_BITS-1 -: ADDR_BITS];
            data_last_reg  <= ((i_reg + CNT_BITS'(1)) == n_reg);
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.out_address    = out_addr_reg;
    assign res.out_value      = out_value_reg;
    assign res.follow_address = out_follow_reg;
    assign res.follow_is_end  = out_follow_end_reg;
    assign res.last_of_run    = out_last_reg;

`ifndef NO_ASSERTIONS
    a_gather_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GATHER) |-> (n_reg < k_reg))
        else $error("Group gather ran past the group size.");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (i_reg <= n_reg))
        else $error("More buffer reads issued than nodes gathered.");

    a_avail_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        data_avail_reg |-> (state_reg == ST_EMIT))
        else $error("Buffer read data pending outside the emit phase.");

    a_move_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("Result moved but output register not valid.");

    a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> ((k_reg >= CNT_BITS'(1)) && (k_reg <= CNT_BITS'(GROUP_MAX))))
        else $error("Effective group size out of range.");
`endif

endmodule

>>> sim/lkg_reorder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lkg_reorder_checker
// Watches the register port and both channels of the group reverser. It keeps
// its own node tables, walk position and register copies, works out the node
// order that each emit transfer must produce, and compares every result
// transfer field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module lkg_reorder_checker
    import lkg_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    lkg_cmd_if                       cmd,
    lkg_res_if                       res,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);

    localparam int GROUP_LIMIT = 64;
    localparam logic [HEAD_BITS:0] WALK_DONE = {1'b1, {HEAD_BITS{1'b0}}};

    typedef struct packed {
        logic [HEAD_BITS-1:0] address;
        logic signed [31:0]   value;
        logic [HEAD_BITS-1:0] follow;
        logic                 follow_end;
        logic                 last;
    } node_result_t;

    node_result_t         expected_nodes[$];
    logic signed [31:0]   value_mem[int];
    logic [HEAD_BITS:0]   link_mem[int];
    logic [GS_BITS-1:0]   group_size;
    logic [HEAD_BITS-1:0] head_address;
    logic [HEAD_BITS:0]   walk_ptr;
    logic                 walk_started;

    function automatic void reorder_next_group();
        int unsigned          k;
        int unsigned          n;
        int unsigned          m;
        int unsigned          i;
        int unsigned          idx;
        logic [HEAD_BITS-1:0] members[GROUP_LIMIT];
        logic [HEAD_BITS-1:0] p;
        logic [HEAD_BITS-1:0] lookp;
        logic [HEAD_BITS-1:0] kth;
        logic [HEAD_BITS-1:0] follow;
        logic [HEAD_BITS:0]   lnk;
        logic                 at_end;
        logic                 look_end;
        logic                 full;
        logic                 follow_end;
        node_result_t         r;

        if (!walk_started)
        begin
            walk_ptr     = {1'b0, head_address};
            walk_started = 1'b1;
        end
        if (walk_ptr[HEAD_BITS])
            return;

        k = (group_size < 2) ? 1 : ((group_size > GROUP_LIMIT) ? GROUP_LIMIT : group_size);

        n      = 0;
        p      = walk_ptr[HEAD_BITS-1:0];
        at_end = 1'b0;
        while (n < k && !at_end)
        begin
            lnk        = link_mem[p];
            members[n] = p;
            n++;
            if (lnk[HEAD_BITS])
                at_end = 1'b1;
            else
                p = lnk[HEAD_BITS-1:0];
        end
        full = (n == k);

        // The node after a group is the head of the next reordered group,
        // which is the k-th node ahead when that group is full.
        follow     = '0;
        follow_end = 1'b1;
        if (!at_end)
        begin
            lookp    = p;
            kth      = p;
            m        = 0;
            look_end = 1'b0;
            while (m < k && !look_end)
            begin
                lnk = link_mem[lookp];
                kth = lookp;
                m++;
                if (lnk[HEAD_BITS])
                    look_end = 1'b1;
                else
                    lookp = lnk[HEAD_BITS-1:0];
            end
            follow     = (m == k) ? kth : p;
            follow_end = 1'b0;
        end

        for (i = 0; i < n; i++)
        begin
            idx       = full ? (n - 1 - i) : i;
            r.address = members[idx];
            r.value   = value_mem[members[idx]];
            if (i + 1 < n)
            begin
                r.follow     = full ? members[n - 2 - i] : members[i + 1];
                r.follow_end = 1'b0;
                r.last       = 1'b0;
            end
            else
            begin
                r.follow     = follow_end ? '0 : follow;
                r.follow_end = follow_end;
                r.last       = 1'b1;
            end
            expected_nodes.push_back(r);
        end

        walk_ptr = at_end ? WALK_DONE : {1'b0, p};
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        node_result_t want;

        if (!rst_n)
        begin
            expected_nodes.delete();
            value_mem.delete();
            link_mem.delete();
            group_size   = GS_RESET;
            head_address = '0;
            walk_ptr     = '0;
            walk_started = 1'b0;
            fail_count   = 0;
            checked      = 0;
        end
        else
        begin
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                checked++;
                if (expected_nodes.size() == 0)
                begin
                    $error("out_address: expected no transfer, actual %0h", res.out_address);
                    fail_count++;
                end
                else
                begin
                    want = expected_nodes.pop_front();
                    check_field("out_address", 32'(want.address), 32'(res.out_address));
                    check_field("out_value", want.value, res.out_value);
                    check_field("follow_address", 32'(want.follow),
                                32'(res.follow_address));
                    check_field("follow_is_end", 32'(want.follow_end),
                                32'(res.follow_is_end));
                    check_field("last_of_run", 32'(want.last), 32'(res.last_of_run));
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_GROUP_SIZE, 2'b00})
                    group_size = pwdata[GS_BITS-1:0];
                else if (paddr == {REG_HEAD_ADDRESS, 2'b00})
                begin
                    head_address = pwdata[HEAD_BITS-1:0];
                    walk_started = 1'b0;
                end
            end

            if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
            begin
                if (cmd.op == OP_LOAD)
                begin
                    value_mem[cmd.node_address] = cmd.node_value;
                    link_mem[cmd.node_address]  = {cmd.link_is_end, cmd.link_address};
                end
                else
                    reorder_next_group();
            end
        end
        pending = expected_nodes.size();
    end

endmodule

>>> sim/tb_linked_list_k_group_reverser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linked_list_k_group_reverser
// Loads node chains into the group reverser, points the head register at
// them and walks them with emit requests under several group sizes, with
// cyclic chains, relinked nodes and stray loads mixed in. Both channels idle
// at random in phases; a separate checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_linked_list_k_group_reverser;
    import lkg_pkg::*;

    localparam int     CLK_PERIOD    = 20;
    localparam int     RESET_CYCLES  = 6;
    localparam int     SETTLE_CYCLES = 250;
    localparam int     HOLD_CYCLES   = 600;
    localparam int     ITEM_TARGET   = 200;
    localparam int     HOLD_PHASE    = 2;
    localparam int     MAX_ADDR      = (1 << HEAD_BITS) - 1;
    localparam longint RUN_LIMIT_NS  = 64'd20_000_000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_pending;
    int items_sent;
    int loads_sent;
    int emits_sent;

    logic [HEAD_BITS-1:0] chain_nodes[$];
    logic [HEAD_BITS-1:0] written_q[$];
    bit                   written[int];

    lkg_cmd_if cmd();
    lkg_res_if res();

    linked_list_k_group_reverser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd),
        .res     (res)
    );

    lkg_reorder_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .cmd        (cmd),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic void plan_chain(input int len);
        bit                   taken[int];
        logic [HEAD_BITS-1:0] addr;

        chain_nodes.delete();
        while (chain_nodes.size() < len)
        begin
            addr = HEAD_BITS'($urandom_range(MAX_ADDR));
            if (!taken.exists(addr))
            begin
                taken[addr] = 1'b1;
                chain_nodes.push_back(addr);
            end
        end
    endfunction

    task automatic send_item(input logic op, input logic [HEAD_BITS-1:0] addr,
                             input logic signed [31:0] value,
                             input logic [HEAD_BITS-1:0] link, input logic is_end);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid        <= 1'b1;
        cmd.op           <= op;
        cmd.node_address <= addr;
        cmd.node_value   <= value;
        cmd.link_address <= link;
        cmd.link_is_end  <= is_end;
        @(posedge clk);
        while (cmd.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_node(input logic [HEAD_BITS-1:0] addr,
                             input logic signed [31:0] value,
                             input logic [HEAD_BITS-1:0] link, input logic is_end);
        send_item(OP_LOAD, addr, value, link, is_end);
        loads_sent++;
        if (!written.exists(addr))
        begin
            written[addr] = 1'b1;
            written_q.push_back(addr);
        end
    endtask

    task automatic emit_group();
        send_item(OP_EMIT, HEAD_BITS'($urandom_range(MAX_ADDR)), $urandom(),
                  HEAD_BITS'($urandom_range(MAX_ADDR)), 1'($urandom_range(1)));
        emits_sent++;
    endtask

    task automatic load_chain(input bit cyclic);
        int i;

        for (i = 0; i < chain_nodes.size(); i++)
        begin
            if (i + 1 < chain_nodes.size())
                load_node(chain_nodes[i], pick_value(), chain_nodes[i + 1], 1'b0);
            else if (cyclic)
                load_node(chain_nodes[i], pick_value(), chain_nodes[$urandom_range(i)], 1'b0);
            else
                load_node(chain_nodes[i], pick_value(),
                          HEAD_BITS'($urandom_range(MAX_ADDR)), 1'b1);
        end
    endtask

    // Noise loads either relink a node of the current chain or add a stray
    // node; a link that is followed always targets a node already written.
    task automatic walk_chain(input int runs, input int noise_pct);
        int                   r;
        logic [HEAD_BITS-1:0] addr;

        r = 0;
        while (r < runs)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                if ($urandom_range(1))
                    addr = chain_nodes[$urandom_range(chain_nodes.size() - 1)];
                else
                    addr = HEAD_BITS'($urandom_range(MAX_ADDR));
                if ($urandom_range(2) == 0)
                    load_node(addr, pick_value(), HEAD_BITS'($urandom_range(MAX_ADDR)),
                              1'b1);
                else
                    load_node(addr, pick_value(),
                              written_q[$urandom_range(written_q.size() - 1)], 1'b0);
            end
            else
            begin
                emit_group();
                r++;
            end
        end
    endtask

    task automatic reg_write(input logic idx, input int unsigned data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int extreme_sizes[7];
        int phase;
        int gsize;
        int keff;
        int len;
        int runs;
        bit cyclic;

        extreme_sizes    = '{0, 1, 2, 64, 127, 3, 65};
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd.valid        = 1'b0;
        cmd.op           = OP_LOAD;
        cmd.node_address = '0;
        cmd.node_value   = '0;
        cmd.link_address = '0;
        cmd.link_is_end  = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_pending     = 1'b0;
        items_sent       = 0;
        loads_sent       = 0;
        emits_sent       = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at reset: group size 1, head at address 0. The third
        // emit finds the walk already finished.
        load_node('0, 32'sh8000_0000, HEAD_BITS'(MAX_ADDR), 1'b0);
        load_node(HEAD_BITS'(MAX_ADDR), 32'sh7FFF_FFFF, HEAD_BITS'(MAX_ADDR), 1'b1);
        repeat (3) emit_group();

        settle();
        reg_write(REG_GROUP_SIZE, 0);
        reg_write(REG_HEAD_ADDRESS, 0);
        repeat (2) emit_group();

        // One full group reversed, then a short remainder in original order.
        plan_chain(5);
        settle();
        reg_write(REG_GROUP_SIZE, 3);
        reg_write(REG_HEAD_ADDRESS, 32'(chain_nodes[0]));
        load_chain(1'b0);
        repeat (3) emit_group();

        plan_chain(3);
        settle();
        reg_write(REG_GROUP_SIZE, 2);
        reg_write(REG_HEAD_ADDRESS, 32'(chain_nodes[0]));
        load_chain(1'b1);
        repeat (3) emit_group();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase

            if (phase < 7)
                gsize = extreme_sizes[phase];
            else if ($urandom_range(99) < 70)
                gsize = $urandom_range(2, 8);
            else if ($urandom_range(1))
                gsize = $urandom_range(1);
            else
                gsize = $urandom_range(9, 127);
            keff = (gsize < 2) ? 1 : ((gsize > 64) ? 64 : gsize);

            if (phase == HOLD_PHASE)
                len = 24;
            else if (gsize == 64)
                len = 66;
            else if (keff > 8)
                len = $urandom_range(1, 24);
            else
                len = $urandom_range(1, 3 * keff + 2);
            cyclic = ($urandom_range(9) == 0);

            plan_chain(len);
            settle();
            reg_write(REG_GROUP_SIZE, gsize);
            reg_write(REG_HEAD_ADDRESS, 32'(chain_nodes[0]));
            load_chain(cyclic);

            if (phase == HOLD_PHASE)
                hold_pending = 1'b1;
            if (cyclic)
                runs = $urandom_range(2, 4);
            else
                runs = (len + keff - 1) / keff + $urandom_range(0, 2);
            walk_chain(runs, (phase % 3 == 0) ? 20 : 5);

            // A new group size in the middle of a walk keeps the walk going.
            if ($urandom_range(3) == 0)
            begin
                settle();
                reg_write(REG_GROUP_SIZE, $urandom_range(8));
                walk_chain(2, 0);
            end
            phase++;
        end

        settle();
        $display("Run covered %0d node loads and %0d emit requests in %0d phases,",
                 loads_sent, emits_sent, phase);
        $display("with group sizes from 0 to 127 and %0d result transfers compared.", checked);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
